// File: src/ipv4dq_pkg.sv
// ipv4dq_pkg: shared types, character codes and error codes for the dotted-quad validator
// used by ipv4dq_close and ipv4_dotted_quad_validator_core; no dependencies
`default_nettype none

package ipv4dq_pkg;

  // character codes
  localparam logic [7:0] CH_DOT  = 8'd46;
  localparam logic [7:0] CH_ZERO = 8'd48;
  localparam logic [7:0] CH_ONE  = 8'd49;
  localparam logic [7:0] CH_NINE = 8'd57;

  // cell checks and saturation limits
  localparam logic [3:0] BINARY_MIN_LEN = 4'd3;
  localparam logic [8:0] VALUE_SAT      = 9'd511;
  localparam logic [3:0] LENGTH_SAT     = 4'd15;
  localparam logic [2:0] COUNT_SAT      = 3'd7;

  // error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_LEADZERO = 3'd1;
  localparam logic [2:0] ERR_BINARY   = 3'd2;
  localparam logic [2:0] ERR_RANGE    = 3'd3;
  localparam logic [2:0] ERR_SEP      = 3'd4;
  localparam logic [2:0] ERR_EMPTY    = 3'd5;
  localparam logic [2:0] ERR_TOO_MANY = 3'd6;
  localparam logic [2:0] ERR_TOO_FEW  = 3'd7;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CELL_VALUE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_EXPECTED = 2'd1;

  localparam logic [7:0] MAX_CELL_VALUE_RST = 8'd255;
  localparam logic [2:0] CELLS_EXPECTED_RST = 3'd4;

  // state of the cell being collected
  typedef struct packed {
    logic [8:0] value;
    logic [3:0] length;
    logic       starts_zero;
    logic       all_binary;
  } cell_t;

  // per-string tally of cells and first error
  typedef struct packed {
    logic [2:0] seen;
    logic       over;
    logic [2:0] err;
    logic [2:0] err_cell;
  } tally_t;

  localparam cell_t CELL_RST = '{
    value: 9'd0, length: 4'd0, starts_zero: 1'b0, all_binary: 1'b1
  };

  localparam tally_t TALLY_RST = '{
    seen: 3'd0, over: 1'b0, err: ERR_NONE, err_cell: 3'd0
  };

endpackage

`default_nettype wire

// File: src/ipv4dq_close.sv
// ipv4dq_close: checks one closing cell and updates the cell count and first error
// depends on ipv4dq_pkg
`default_nettype none

module ipv4dq_close (
  input  var ipv4dq_pkg::cell_t  cell_i,
  input  var ipv4dq_pkg::tally_t tally_i,
  input  wire                    check_sep_i,
  input  wire [7:0]              ch_i,
  input  wire [7:0]              max_cell_value_i,
  output ipv4dq_pkg::tally_t     tally_o
);

  logic [2:0] seen_inc;
  logic [2:0] code;

  // saturating cell count
  assign seen_inc = (tally_i.seen < ipv4dq_pkg::COUNT_SAT) ? tally_i.seen + 3'd1
                                                          : tally_i.seen;

  // first failing check in priority order
  always_comb begin
    priority if (check_sep_i && (ch_i != ipv4dq_pkg::CH_DOT)) begin
      code = ipv4dq_pkg::ERR_SEP;
    end else if (cell_i.length == 4'd0) begin
      code = ipv4dq_pkg::ERR_EMPTY;
    end else if (cell_i.starts_zero && (cell_i.length > 4'd1)) begin
      code = ipv4dq_pkg::ERR_LEADZERO;
    end else if (cell_i.all_binary && (cell_i.length > ipv4dq_pkg::BINARY_MIN_LEN)) begin
      code = ipv4dq_pkg::ERR_BINARY;
    end else if (cell_i.value > {1'b0, max_cell_value_i}) begin
      code = ipv4dq_pkg::ERR_RANGE;
    end else begin
      code = ipv4dq_pkg::ERR_NONE;
    end
  end

  // keep only the first error of the string
  always_comb begin
    tally_o      = tally_i;
    tally_o.seen = seen_inc;
    tally_o.over = tally_i.over | (tally_i.seen == ipv4dq_pkg::COUNT_SAT);
    if ((tally_i.err == ipv4dq_pkg::ERR_NONE) && (code != ipv4dq_pkg::ERR_NONE)) begin
      tally_o.err      = code;
      tally_o.err_cell = seen_inc;
    end
  end

endmodule

`default_nettype wire

// File: src/ipv4_dotted_quad_validator_core.sv
// ipv4_dotted_quad_validator_core: character-stream dotted address validator, top level
// depends on ipv4dq_pkg and ipv4dq_close
//
//  channel   dir  payload                                          transaction
//  s_axis    in   tdata[7:0] ch, tlast last                        one character
//  m_axis    out  tdata valid_res, error_code, error_cell, total   one result per string
//  cfg       in   cfg_index_i register index, cfg_data_i value     one register write
//
// one character per cycle: the cell accumulate, both cell closes and the count
// check sit between the state registers and the result register
// a result appears in the cycle after the character that carries tlast
// reset restores max_cell_value 255 and cells_expected 4 and clears the string state
// s_axis_tready drops only while a result is held and m_axis_tready is low
`default_nettype none

module ipv4_dotted_quad_validator_core (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // input stream
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire [7:0]                        s_axis_tdata,   // [7:0] ch
  input  wire                              s_axis_tlast,
  // result stream
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  output logic [15:0]                      m_axis_tdata,   // [0] valid_res, [3:1] error_code,
                                                           // [6:4] error_cell, [9:7] cell_total
  // configuration writes
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire [ipv4dq_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire [7:0]                        cfg_data_i
);

  logic [7:0] max_cell_value_q;
  logic [2:0] cells_expected_q;

  ipv4dq_pkg::cell_t  cell_q, cell_d, cell_add, cell_mid;
  ipv4dq_pkg::tally_t tally_q, tally_d, tally_close0, tally_mid, tally_close1, tally_end;

  logic        in_accept;
  logic        is_digit;
  logic [12:0] acc_full;
  logic        out_valid_q;
  logic        res_valid_q;
  logic [2:0]  res_code_q;
  logic [2:0]  res_cell_q;
  logic [2:0]  res_total_q;

  assign in_accept     = s_axis_tvalid & s_axis_tready;
  assign s_axis_tready = ~out_valid_q | m_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_cell_value_q <= ipv4dq_pkg::MAX_CELL_VALUE_RST;
      cells_expected_q <= ipv4dq_pkg::CELLS_EXPECTED_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ipv4dq_pkg::CFG_MAX_CELL_VALUE: max_cell_value_q <= cfg_data_i;
        ipv4dq_pkg::CFG_CELLS_EXPECTED: cells_expected_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  assign is_digit = (s_axis_tdata >= ipv4dq_pkg::CH_ZERO) &&
                    (s_axis_tdata <= ipv4dq_pkg::CH_NINE);

  // digit accumulate with saturation
  assign acc_full = {4'd0, cell_q.value} * 13'd10 + {9'd0, s_axis_tdata[3:0]};

  always_comb begin
    cell_add = cell_q;
    cell_add.value = (acc_full > {4'd0, ipv4dq_pkg::VALUE_SAT}) ? ipv4dq_pkg::VALUE_SAT
                                                               : acc_full[8:0];
    if ((cell_q.length == 4'd0) && (s_axis_tdata == ipv4dq_pkg::CH_ZERO)) begin
      cell_add.starts_zero = 1'b1;
    end
    if ((s_axis_tdata != ipv4dq_pkg::CH_ZERO) && (s_axis_tdata != ipv4dq_pkg::CH_ONE)) begin
      cell_add.all_binary = 1'b0;
    end
    if (cell_q.length < ipv4dq_pkg::LENGTH_SAT) begin
      cell_add.length = cell_q.length + 4'd1;
    end
  end

  // close on a separator character
  ipv4dq_close u_close_sep (
    .cell_i           (cell_q),
    .tally_i          (tally_q),
    .check_sep_i      (1'b1),
    .ch_i             (s_axis_tdata),
    .max_cell_value_i (max_cell_value_q),
    .tally_o          (tally_close0)
  );

  assign cell_mid  = is_digit ? cell_add : ipv4dq_pkg::CELL_RST;
  assign tally_mid = is_digit ? tally_q  : tally_close0;

  // close at the end of the string
  ipv4dq_close u_close_end (
    .cell_i           (cell_mid),
    .tally_i          (tally_mid),
    .check_sep_i      (1'b0),
    .ch_i             (s_axis_tdata),
    .max_cell_value_i (max_cell_value_q),
    .tally_o          (tally_close1)
  );

  // cell count check
  always_comb begin
    tally_end = tally_close1;
    if (tally_close1.err == ipv4dq_pkg::ERR_NONE) begin
      priority if (tally_close1.over || (tally_close1.seen > cells_expected_q)) begin
        tally_end.err      = ipv4dq_pkg::ERR_TOO_MANY;
        tally_end.err_cell = tally_close1.seen;
      end else if (tally_close1.seen < cells_expected_q) begin
        tally_end.err      = ipv4dq_pkg::ERR_TOO_FEW;
        tally_end.err_cell = tally_close1.seen;
      end else begin
        tally_end.err      = ipv4dq_pkg::ERR_NONE;
      end
    end
  end

  assign cell_d  = s_axis_tlast ? ipv4dq_pkg::CELL_RST  : cell_mid;
  assign tally_d = s_axis_tlast ? ipv4dq_pkg::TALLY_RST : tally_mid;

  // string state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q  <= ipv4dq_pkg::CELL_RST;
      tally_q <= ipv4dq_pkg::TALLY_RST;
    end else if (in_accept) begin
      cell_q  <= cell_d;
      tally_q <= tally_d;
    end
  end

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept && s_axis_tlast) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_accept && s_axis_tlast) begin
      res_valid_q <= (tally_end.err == ipv4dq_pkg::ERR_NONE);
      res_code_q  <= tally_end.err;
      res_cell_q  <= tally_end.err_cell;
      res_total_q <= tally_end.seen;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, res_total_q, res_cell_q, res_code_q, res_valid_q};

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// tb: self-checking testbench for ipv4_dotted_quad_validator_core
// streams address strings one character per transaction and checks each verdict against
// a cycle-free predictor; depends on ipv4dq_pkg and the core RTL
`timescale 1ns / 100ps

module tb;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned LONG_HOLD      = 80;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned PHASES         = 6;
  localparam int unsigned PHASE_CHARS    = 150;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_item_t;

  typedef struct packed {
    logic       ok;
    logic [2:0] code;
    logic [2:0] err_cell;
    logic [2:0] total;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [7:0]                       s_axis_tdata  = '0;
  logic                             s_axis_tlast  = 1'b0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [15:0]                      m_axis_tdata;
  logic                             cfg_valid_i   = 1'b0;
  logic                             cfg_ready_o;
  logic [ipv4dq_pkg::CFG_IDX_W-1:0] cfg_index_i   = '0;
  logic [7:0]                       cfg_data_i    = '0;

  ipv4_dotted_quad_validator_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  char_item_t   char_q[$];
  verdict_t     verdict_q[$];
  byte unsigned line_buf[$];

  int unsigned mismatches      = 0;
  int unsigned send_gap        = 0;
  int unsigned rcv_hold        = 0;
  int unsigned quiet_cycles    = 0;
  int unsigned phase_chars     = 0;
  logic        no_idle         = 1'b0;
  logic        long_hold_req   = 1'b0;
  logic        long_hold_taken = 1'b0;

  // register shadows
  logic [7:0] lim_value  = ipv4dq_pkg::MAX_CELL_VALUE_RST;
  logic [2:0] want_cells = ipv4dq_pkg::CELLS_EXPECTED_RST;

  // predictor state for the string in progress
  logic [8:0] acc_val   = '0;
  logic [3:0] acc_len   = '0;
  logic       acc_lead0 = 1'b0;
  logic       acc_bin   = 1'b1;
  logic [2:0] n_cells   = '0;
  logic       n_over    = 1'b0;
  logic [2:0] err_first = ipv4dq_pkg::ERR_NONE;
  logic [2:0] err_at    = '0;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void clear_string();
    acc_val   = '0;
    acc_len   = '0;
    acc_lead0 = 1'b0;
    acc_bin   = 1'b1;
    n_cells   = '0;
    n_over    = 1'b0;
    err_first = ipv4dq_pkg::ERR_NONE;
    err_at    = '0;
  endfunction

  // only the first error of a string is kept
  function automatic void flag_err(logic [2:0] code);
    if (err_first == ipv4dq_pkg::ERR_NONE) begin
      err_first = code;
      err_at    = n_cells;
    end
  endfunction

  function automatic void take_digit(logic [7:0] c);
    int unsigned v;
    if (acc_len == 0 && c == ipv4dq_pkg::CH_ZERO) acc_lead0 = 1'b1;
    if (c != ipv4dq_pkg::CH_ZERO && c != ipv4dq_pkg::CH_ONE) acc_bin = 1'b0;
    v = acc_val * 10 + (c - ipv4dq_pkg::CH_ZERO);
    acc_val = (v > ipv4dq_pkg::VALUE_SAT) ? ipv4dq_pkg::VALUE_SAT : v[8:0];
    if (acc_len < ipv4dq_pkg::LENGTH_SAT) acc_len = acc_len + 1'b1;
  endfunction

  // close a cell: separator, then empty, leading zero, binary, range
  function automatic void end_cell(logic chk_sep, logic [7:0] c);
    if (n_cells < ipv4dq_pkg::COUNT_SAT) n_cells = n_cells + 1'b1;
    else n_over = 1'b1;
    if (chk_sep && c != ipv4dq_pkg::CH_DOT) flag_err(ipv4dq_pkg::ERR_SEP);
    if (acc_len == 0) flag_err(ipv4dq_pkg::ERR_EMPTY);
    else if (acc_lead0 && acc_len > 1) flag_err(ipv4dq_pkg::ERR_LEADZERO);
    else if (acc_bin && acc_len > ipv4dq_pkg::BINARY_MIN_LEN) flag_err(ipv4dq_pkg::ERR_BINARY);
    else if (acc_val > {1'b0, lim_value}) flag_err(ipv4dq_pkg::ERR_RANGE);
    acc_val   = '0;
    acc_len   = '0;
    acc_lead0 = 1'b0;
    acc_bin   = 1'b1;
  endfunction

  // advance the predictor by one accepted character, queue a verdict at end of string
  function automatic void predict_verdict(logic [7:0] c, logic last);
    verdict_t v;
    if (c >= ipv4dq_pkg::CH_ZERO && c <= ipv4dq_pkg::CH_NINE) take_digit(c);
    else end_cell(1'b1, c);
    if (last) begin
      end_cell(1'b0, 8'd0);
      if (n_over || n_cells > want_cells) flag_err(ipv4dq_pkg::ERR_TOO_MANY);
      else if (n_cells < want_cells) flag_err(ipv4dq_pkg::ERR_TOO_FEW);
      v.ok       = (err_first == ipv4dq_pkg::ERR_NONE);
      v.code     = err_first;
      v.err_cell = err_at;
      v.total    = n_cells;
      verdict_q.push_back(v);
      clear_string();
    end
  endfunction

  // input driver
  always @(posedge clk_i) begin : drv
    char_item_t it;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) predict_verdict(s_axis_tdata, s_axis_tlast);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap = send_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (char_q.size() > 0) begin
          it = char_q.pop_front();
          s_axis_tdata  <= it.ch;
          s_axis_tlast  <= it.last;
          s_axis_tvalid <= 1'b1;
          send_gap = no_idle ? 0 : pick_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk_i) begin : mon
    verdict_t want;
    verdict_t got;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.ok       = m_axis_tdata[0];
        got.code     = m_axis_tdata[3:1];
        got.err_cell = m_axis_tdata[6:4];
        got.total    = m_axis_tdata[9:7];
        if (verdict_q.size() == 0) begin
          $error("unexpected result transaction, tdata %h", m_axis_tdata);
          mismatches = mismatches + 1;
        end else begin
          want = verdict_q.pop_front();
          if (got.ok != want.ok) begin
            $error("valid_res: expected %0d, actual %0d", want.ok, got.ok);
            mismatches = mismatches + 1;
          end
          if (got.code != want.code) begin
            $error("error_code: expected %0d, actual %0d", want.code, got.code);
            mismatches = mismatches + 1;
          end
          if (got.err_cell != want.err_cell) begin
            $error("error_cell: expected %0d, actual %0d", want.err_cell, got.err_cell);
            mismatches = mismatches + 1;
          end
          if (got.total != want.total) begin
            $error("cell_total: expected %0d, actual %0d", want.total, got.total);
            mismatches = mismatches + 1;
          end
        end
      end
      if (long_hold_req && !long_hold_taken) begin
        rcv_hold = LONG_HOLD;
        long_hold_taken = 1'b1;
      end
      if (rcv_hold > 0) begin
        rcv_hold = rcv_hold - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!no_idle) rcv_hold = pick_gap();
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("tb: FAIL");
          $finish;
        end
      end
    end
  end

  task automatic write_reg(input logic [ipv4dq_pkg::CFG_IDX_W-1:0] idx,
                           input logic [7:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == ipv4dq_pkg::CFG_MAX_CELL_VALUE) lim_value = val;
    else if (idx == ipv4dq_pkg::CFG_CELLS_EXPECTED) want_cells = val[2:0];
  endtask

  // sender holds off until every verdict has arrived
  task automatic wait_drained();
    do @(posedge clk_i);
    while (char_q.size() != 0 || s_axis_tvalid || verdict_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // move the line buffer into the pending queue, last flag on the final character
  function automatic void flush_line();
    char_item_t it;
    for (int i = 0; i < line_buf.size(); i++) begin
      it.ch   = line_buf[i];
      it.last = (i == line_buf.size() - 1);
      char_q.push_back(it);
    end
    phase_chars = phase_chars + line_buf.size();
    line_buf.delete();
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  function automatic void put_digits(int unsigned v);
    put_text($sformatf("%0d", v));
  endfunction

  function automatic byte unsigned pick_sep();
    byte unsigned c;
    if ($urandom_range(0, 99) < 92) return ipv4dq_pkg::CH_DOT;
    do c = 8'($urandom_range(0, 255));
    while (c >= ipv4dq_pkg::CH_ZERO && c <= ipv4dq_pkg::CH_NINE);
    return c;
  endfunction

  // one cell of random shape: plain decimal, leading zero, binary, long, empty, single digit
  function automatic void put_cell();
    int unsigned k;
    int unsigned n;
    k = $urandom_range(0, 99);
    if (k < 55) begin
      if ($urandom_range(0, 1)) put_digits($urandom_range(0, 255));
      else put_digits(lim_value + $urandom_range(0, 2));
    end else if (k < 65) begin
      line_buf.push_back(ipv4dq_pkg::CH_ZERO);
      put_digits($urandom_range(0, 99));
    end else if (k < 75) begin
      n = $urandom_range(3, 6);
      repeat (n) begin
        line_buf.push_back($urandom_range(0, 1) ? ipv4dq_pkg::CH_ONE : ipv4dq_pkg::CH_ZERO);
      end
    end else if (k < 82) begin
      n = $urandom_range(4, 18);
      repeat (n) line_buf.push_back(8'(ipv4dq_pkg::CH_ZERO + $urandom_range(0, 9)));
    end else if (k >= 88) begin
      line_buf.push_back(8'(ipv4dq_pkg::CH_ZERO + $urandom_range(0, 9)));
    end
  endfunction

  // mostly dotted strings with random cells, the rest raw byte noise
  function automatic void put_line();
    int unsigned n;
    if ($urandom_range(0, 99) < 75) begin
      n = ($urandom_range(0, 99) < 60) ? want_cells : $urandom_range(1, 9);
      for (int i = 0; i < n; i++) begin
        if (i > 0) line_buf.push_back(pick_sep());
        put_cell();
      end
      if ($urandom_range(0, 19) == 0) line_buf.push_back(ipv4dq_pkg::CH_DOT);
    end else begin
      n = $urandom_range(1, 8);
      repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
    end
    if (line_buf.size() == 0) line_buf.push_back(8'($urandom_range(0, 255)));
    flush_line();
  endfunction

  initial begin
    logic [7:0] lim_plan [PHASES];
    logic [2:0] want_plan[PHASES];
    lim_plan  = '{8'd0, 8'd255, 8'd1, 8'd0, 8'd200, 8'd255};
    want_plan = '{3'd1, 3'd7, 3'd4, 3'd1, 3'd2, 3'd4};
    lim_plan[3]  = 8'($urandom_range(0, 255));
    want_plan[3] = 3'($urandom_range(1, 7));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed strings under reset settings
    put_text("255.0.1.9"); flush_line();
    put_text("01");        flush_line();
    put_text("1010");      flush_line();
    put_text("256");       flush_line();
    line_buf.push_back(8'hFF); flush_line();
    line_buf.push_back(8'h00); flush_line();
    put_text(".");         flush_line();
    put_text("9");         flush_line();
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      write_reg(ipv4dq_pkg::CFG_MAX_CELL_VALUE, lim_plan[p]);
      write_reg(ipv4dq_pkg::CFG_CELLS_EXPECTED, {5'd0, want_plan[p]});
      no_idle = (p == 2 || p == 4);
      if (p == 0) long_hold_req = 1'b1;
      phase_chars = 0;
      while (phase_chars < PHASE_CHARS) put_line();
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
